// ===== rtl/core/strict_priority_packet_scheduler_unit_assert.svh =====
// Assertion macros shared by the scheduler RTL files.
`ifndef STRICT_PRIORITY_PACKET_SCHEDULER_UNIT_ASSERT_SVH
`define STRICT_PRIORITY_PACKET_SCHEDULER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too.
`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scheduler assertion failed: same-cycle rule");

// Next-cycle implication: whenever ante holds, cons holds in the next cycle.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scheduler assertion failed: next-cycle rule");

`else

`define SPQ_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/spq_pkg.sv =====
// Shared types, codes and constants of the strict priority scheduler.
`timescale 1ns / 1ps

package spq_pkg;

	localparam int PROTO_W     = 8;
	localparam int PORT_W      = 16;
	localparam int TAG_FIELD_W = 16;
	localparam int STATUS_W    = 3;
	localparam int CLASS_W     = 2;

	localparam logic [PROTO_W-1:0] PROTO_UDP       = 8'd17;
	localparam logic [PROTO_W-1:0] PROTO_TCP       = 8'd6;
	localparam logic [PORT_W-1:0]  HIGH_PORT_RESET = 16'd3000;

	localparam int QUEUE_DEPTH_DEF = 64;
	localparam int TAG_WIDTH_DEF   = 16;

	typedef enum logic {
		MODE_ARRIVAL = 1'b0,
		MODE_DONE    = 1'b1
	} mode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_START     = 3'd0,
		ST_QUEUED    = 3'd1,
		ST_DROPPED   = 3'd2,
		ST_BYPASS    = 3'd3,
		ST_NEXT_HIGH = 3'd4,
		ST_NEXT_LOW  = 3'd5,
		ST_IDLE      = 3'd6
	} status_t;

	typedef enum logic [CLASS_W-1:0] {
		CLS_LOW  = 2'd0,
		CLS_HIGH = 2'd1,
		CLS_TCP  = 2'd2
	} prio_class_t;

	// Command from the scheduler to one tag queue.
	typedef struct packed {
		logic push;
		logic pop;
	} spq_fifo_cmd_t;

	// Occupancy flags reported by one tag queue.
	typedef struct packed {
		logic empty;
		logic full;
	} spq_fifo_stat_t;

endpackage

// ===== rtl/core/spq_in_if.sv =====
// Event input channel: valid/ready handshake with the event word.
`timescale 1ns / 1ps

interface spq_in_if import spq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   mode;
	logic [PROTO_W-1:0]     protocol;
	logic [PORT_W-1:0]      dest_port;
	logic [TAG_FIELD_W-1:0] packet_tag;

	modport source (output valid, mode, protocol, dest_port, packet_tag, input ready);
	modport sink   (input valid, mode, protocol, dest_port, packet_tag, output ready);
endinterface

// ===== rtl/core/spq_out_if.sv =====
// Result output channel: valid/ready handshake with the result word.
`timescale 1ns / 1ps

interface spq_out_if import spq_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [STATUS_W-1:0]    status;
	logic [CLASS_W-1:0]     priority_class;
	logic [TAG_FIELD_W-1:0] next_tag;

	modport source (output valid, status, priority_class, next_tag, input ready);
	modport sink   (input valid, status, priority_class, next_tag, output ready);
endinterface

// ===== rtl/core/strict_priority_packet_scheduler_unit.sv =====
// Top level of the two-level strict priority packet scheduler.
`timescale 1ns / 1ps
`include "strict_priority_packet_scheduler_unit_assert.svh"

// Two-level strict priority scheduler. Each input word is either a packet arrival
// (mode 0) or a processing-complete event (mode 1), and every word yields exactly
// one result word. Arrivals are classified as TCP (protocol 6, passed on with
// status 3), high priority (UDP protocol 17 to the port in the high_port register)
// or low priority. An arrival that finds the processor idle starts at once;
// otherwise its tag goes to the high or low drop-tail queue of QUEUE_DEPTH tags,
// and a full queue drops it. A completion dispatches the oldest high tag, else the
// oldest low tag, else marks the processor idle. Throughput is one word per
// cycle while the output is not stalled, arrivals and completions in any mix; a
// word is captured in the input register, decided there and presented from the
// result register. Each queue is a single-port-write, registered-read memory
// whose head tag is kept in a show-ahead register, refilled from the memory read
// plus a one-entry write bypass, which is what lets completions dispatch back to
// back. Queue contents need no clearing after reset; the block is ready right out
// of reset. Write high_port only while no words are in flight.
module strict_priority_packet_scheduler_unit import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [PORT_W-1:0] cfg_wdata,
	spq_in_if.sink            pkt_in,
	spq_out_if.source         pkt_out
);

	// Configuration and processor state.
	logic [PORT_W-1:0] high_port_q;
	logic              busy_q;

	// Input register.
	logic                   valid_s1;
	logic                   mode_s1;
	logic [PROTO_W-1:0]     protocol_s1;
	logic [PORT_W-1:0]      dest_port_s1;
	logic [TAG_FIELD_W-1:0] packet_tag_s1;

	// Result register.
	logic                   valid_s2;
	status_t                status_s2;
	prio_class_t            prio_s2;
	logic [TAG_FIELD_W-1:0] next_tag_s2;

	// Decision logic.
	logic                   s2_free;
	logic                   fire;
	logic                   is_tcp;
	logic                   is_high;
	logic                   busy_set;
	logic                   busy_clr;
	status_t                status_c;
	prio_class_t            prio_c;
	logic [TAG_FIELD_W-1:0] tag_c;
	logic [TAG_WIDTH-1:0]   push_tag;

	// Queue interfaces.
	spq_fifo_cmd_t        hi_cmd;
	spq_fifo_cmd_t        lo_cmd;
	spq_fifo_stat_t       hi_stat;
	spq_fifo_stat_t       lo_stat;
	logic [TAG_WIDTH-1:0] hi_head;
	logic [TAG_WIDTH-1:0] lo_head;

	// The result register frees up when it is empty or being taken this cycle;
	// the input register can then both hand its word over and take a new one.
	assign s2_free      = !valid_s2 || pkt_out.ready;
	assign fire         = valid_s1 && s2_free;
	assign pkt_in.ready = !valid_s1 || s2_free;

	// Classify the held arrival.
	assign is_tcp   = (protocol_s1 == PROTO_TCP);
	assign is_high  = (protocol_s1 == PROTO_UDP) && (dest_port_s1 == high_port_q);
	assign push_tag = TAG_WIDTH'(packet_tag_s1);

	// Decide the outcome of the word in the input register. Queue commands and
	// busy changes are gated by fire so state moves only when the result is taken
	// into the result register.
	always_comb begin
		hi_cmd   = '0;
		lo_cmd   = '0;
		busy_set = 1'b0;
		busy_clr = 1'b0;
		status_c = ST_IDLE;
		prio_c   = CLS_LOW;
		tag_c    = '0;
		if (mode_s1 == MODE_ARRIVAL) begin
			if (is_tcp) begin
				// TCP never touches the queues or the processor.
				status_c = ST_BYPASS;
				prio_c   = CLS_TCP;
			end else begin
				prio_c = is_high ? CLS_HIGH : CLS_LOW;
				if (!busy_q) begin
					// Idle processor: start this packet right away.
					busy_set = fire;
					status_c = ST_START;
				end else if (is_high) begin
					if (hi_stat.full) begin
						status_c = ST_DROPPED;
					end else begin
						hi_cmd.push = fire;
						status_c    = ST_QUEUED;
					end
				end else begin
					if (lo_stat.full) begin
						status_c = ST_DROPPED;
					end else begin
						lo_cmd.push = fire;
						status_c    = ST_QUEUED;
					end
				end
			end
		end else begin
			// Completion: high queue first, then low, else go idle.
			if (!hi_stat.empty) begin
				hi_cmd.pop = fire;
				status_c   = ST_NEXT_HIGH;
				tag_c      = TAG_FIELD_W'(hi_head);
			end else if (!lo_stat.empty) begin
				lo_cmd.pop = fire;
				status_c   = ST_NEXT_LOW;
				tag_c      = TAG_FIELD_W'(lo_head);
			end else begin
				busy_clr = fire;
				status_c = ST_IDLE;
			end
		end
	end

	spq_tag_fifo #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_WIDTH   (TAG_WIDTH)
	) u_high_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (hi_cmd),
		.push_tag (push_tag),
		.stat     (hi_stat),
		.head_tag (hi_head)
	);

	spq_tag_fifo #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.TAG_WIDTH   (TAG_WIDTH)
	) u_low_q (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (lo_cmd),
		.push_tag (push_tag),
		.stat     (lo_stat),
		.head_tag (lo_head)
	);

	// Control state: configuration, busy flag and the two valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_port_q <= HIGH_PORT_RESET;
			busy_q      <= 1'b0;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
		end else begin
			if (cfg_we) begin
				high_port_q <= cfg_wdata;
			end
			if (busy_set) begin
				busy_q <= 1'b1;
			end else if (busy_clr) begin
				busy_q <= 1'b0;
			end
			if (pkt_in.ready) begin
				valid_s1 <= pkt_in.valid;
			end
			if (s2_free) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Payload registers: capture on accept, advance on fire, hold otherwise.
	always_ff @(posedge clk) begin
		if (pkt_in.valid && pkt_in.ready) begin
			mode_s1       <= pkt_in.mode;
			protocol_s1   <= pkt_in.protocol;
			dest_port_s1  <= pkt_in.dest_port;
			packet_tag_s1 <= pkt_in.packet_tag;
		end
		if (fire) begin
			status_s2   <= status_c;
			prio_s2     <= prio_c;
			next_tag_s2 <= tag_c;
		end
	end

	assign pkt_out.valid          = valid_s2;
	assign pkt_out.status         = status_s2;
	assign pkt_out.priority_class = prio_s2;
	assign pkt_out.next_tag       = next_tag_s2;

	`SPQ_ASSERT_IMPL(a_idle_queues_empty, clk, arst_n, !busy_q, hi_stat.empty && lo_stat.empty)
	`SPQ_ASSERT_NEXT(a_fire_loads_result, clk, arst_n, fire, valid_s2)
	`SPQ_ASSERT_NEXT(a_stall_holds_word, clk, arst_n, valid_s1 && !s2_free, valid_s1)
	`SPQ_ASSERT_IMPL(a_one_queue_cmd, clk, arst_n, hi_cmd.push || hi_cmd.pop, !(lo_cmd.push || lo_cmd.pop))

endmodule

// ===== rtl/core/spq_tag_fifo.sv =====
// Drop-tail tag queue: memory with registered read and a show-ahead head register.
`timescale 1ns / 1ps
`include "strict_priority_packet_scheduler_unit_assert.svh"

module spq_tag_fifo import spq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  spq_fifo_cmd_t        cmd,
	input  logic [TAG_WIDTH-1:0] push_tag,
	output spq_fifo_stat_t       stat,
	output logic [TAG_WIDTH-1:0] head_tag
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_IDX = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
	localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		return (p == LAST_IDX) ? '0 : p + 1'b1;
	endfunction

	logic [TAG_WIDTH-1:0] mem [QUEUE_DEPTH];

	logic [PTR_W-1:0]     head_q;
	logic [PTR_W-1:0]     tail_q;
	logic [CNT_W-1:0]     count_q;
	logic [TAG_WIDTH-1:0] head_tag_q;
	logic                 wr_en_q;
	logic [PTR_W-1:0]     wr_addr_q;
	logic [TAG_WIDTH-1:0] wr_data_q;
	logic [TAG_WIDTH-1:0] rd_data_q;

	logic [PTR_W-1:0]     head_inc;
	logic [PTR_W-1:0]     head_nxt;
	logic [TAG_WIDTH-1:0] second_tag;

	assign head_inc = ptr_inc(head_q);
	assign head_nxt = cmd.pop ? head_inc : head_q;

	// rd_data_q holds the entry behind the head; a write in the last cycle to that
	// slot is not yet visible in it.
	assign second_tag = (wr_en_q && (wr_addr_q == head_inc)) ? wr_data_q : rd_data_q;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FULL_CNT);
	assign head_tag   = head_tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			wr_en_q <= 1'b0;
		end else begin
			wr_en_q <= cmd.push;
			if (cmd.push) begin
				tail_q  <= ptr_inc(tail_q);
				count_q <= count_q + 1'b1;
			end else if (cmd.pop) begin
				head_q  <= head_inc;
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			mem[tail_q] <= push_tag;
		end
		rd_data_q <= mem[ptr_inc(head_nxt)];
		wr_addr_q <= tail_q;
		wr_data_q <= push_tag;
		if (cmd.push && stat.empty) begin
			head_tag_q <= push_tag;
		end else if (cmd.pop && (count_q != ONE_CNT)) begin
			head_tag_q <= second_tag;
		end
	end

	`SPQ_ASSERT_IMPL(a_push_pop_excl, clk, arst_n, cmd.push, !cmd.pop)
	`SPQ_ASSERT_IMPL(a_no_push_full, clk, arst_n, cmd.push, !stat.full)
	`SPQ_ASSERT_IMPL(a_no_pop_empty, clk, arst_n, cmd.pop, !stat.empty)
	`SPQ_ASSERT_NEXT(a_first_tag_shown, clk, arst_n, cmd.push && stat.empty, head_tag_q == $past(push_tag))

endmodule
